// File: rtl/acoustic_wave_stencil_2d_macros.svh
// Assertion shorthands used by the checker file of the wave stencil.
// Each one samples on clk and is switched off while rst_n is low.
`ifndef ACOUSTIC_WAVE_STENCIL_2D_MACROS_SVH
`define ACOUSTIC_WAVE_STENCIL_2D_MACROS_SVH

// Same-cycle implication.
`define AWSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AWSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/awsd_pkg.sv
package awsd_pkg;

    localparam int SAMPLE_BITS    = 32;
    localparam int VEL_BITS       = 16;
    localparam int FRAC_BITS      = 16;
    localparam int HEIGHT_BITS    = 11;
    localparam int WEIGHT_BITS    = 8;
    localparam int SELF_BITS      = 3;
    localparam int CFG_INDEX_BITS = 2;
    localparam int SLOT_BITS      = 2;
    localparam int COUNT_BITS     = 3;
    localparam int IN_DATA_BITS   = 2 * SAMPLE_BITS + VEL_BITS;
    localparam int QUEUE_DEPTH    = 2;

    // Stencil reach on each side of the center point.
    localparam int HALO       = 2;
    localparam int MIN_HEIGHT = 5;

    localparam logic [COUNT_BITS-1:0] FULL_COLUMNS = COUNT_BITS'(4);

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NEAR   = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SELF   = 2'd3;

    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 11'd1024;
    localparam logic [WEIGHT_BITS-1:0] NEAR_RESET   = 8'd16;
    localparam logic [WEIGHT_BITS-1:0] CENTER_RESET = 8'd60;
    localparam logic [SELF_BITS-1:0]   SELF_RESET   = 3'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // One classified sample on its way from the front end to the back end.
    typedef struct packed {
        logic                  emit;
        logic [SLOT_BITS-1:0]  slot;
        sample_t               sample;
        logic [VEL_BITS-1:0]   vel;
        sample_t               prev;
    } item_t;

    // Column-store reads of one stencil point, in issue order.
    typedef enum logic [2:0] {
        TAP_CENTER,
        TAP_ROW_M1,
        TAP_ROW_P1,
        TAP_LEFT1,
        TAP_RIGHT1,
        TAP_ROW_M2,
        TAP_ROW_P2,
        TAP_LEFT2
    } tap_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_MUL,
        BK_LAP,
        BK_VEL,
        BK_ROUND,
        BK_SUM,
        BK_DONE
    } back_state_t;

endpackage

// File: rtl/awsd_front.sv
module awsd_front #(
    parameter int ROW_W = 10,
    parameter int H_W   = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          frame_start,
    input  awsd_pkg::sample_t             field_sample,
    input  logic [awsd_pkg::VEL_BITS-1:0] center_vel,
    input  awsd_pkg::sample_t             center_prev,
    input  logic [H_W-1:0]                height,
    input  logic                          full,
    output logic                          push,
    output awsd_pkg::item_t               item,
    output logic [ROW_W-1:0]              row
);

    logic [ROW_W-1:0]                    row_reg, row_next;
    logic [awsd_pkg::SLOT_BITS-1:0]      slot_reg, slot_next;
    logic [awsd_pkg::COUNT_BITS-1:0]     count_reg, count_next;

    logic [ROW_W-1:0]                    row_start;
    logic [awsd_pkg::COUNT_BITS-1:0]     count_start, count_cur;
    logic [awsd_pkg::SLOT_BITS-1:0]      slot_cur;
    logic                                wrap_early;
    logic                                last_row;
    logic                                emit;

    assign in_ready = !full;
    assign push     = in_valid && !full;

    always_comb
    begin
        // A frame start clears row and column count but keeps the ring slot.
        row_start   = frame_start ? '0 : row_reg;
        count_start = frame_start ? '0 : count_reg;

        // The height may have shrunk below the current row: start a new column.
        wrap_early = H_W'(row_start) >= height;
        row        = wrap_early ? '0 : row_start;
        slot_cur   = wrap_early ? slot_reg + 1'b1 : slot_reg;
        count_cur  = (wrap_early && count_start != awsd_pkg::FULL_COLUMNS)
                     ? count_start + 1'b1 : count_start;

        emit = (count_cur == awsd_pkg::FULL_COLUMNS)
            && (H_W'(row) >= H_W'(awsd_pkg::HALO))
            && ((H_W+1)'(row) + (H_W+1)'(awsd_pkg::HALO + 1) <= (H_W+1)'(height));

        last_row   = (H_W'(row) + H_W'(1)) >= height;
        row_next   = last_row ? '0 : ROW_W'(H_W'(row) + H_W'(1));
        slot_next  = last_row ? slot_cur + 1'b1 : slot_cur;
        count_next = (last_row && count_cur != awsd_pkg::FULL_COLUMNS)
                     ? count_cur + 1'b1 : count_cur;

        item.emit   = emit;
        item.slot   = slot_cur;
        item.sample = field_sample;
        item.vel    = center_vel;
        item.prev   = center_prev;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            slot_reg  <= '0;
            count_reg <= '0;
        end
        else if (push)
        begin
            row_reg   <= row_next;
            slot_reg  <= slot_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/awsd_queue.sv
module awsd_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign full     = fill_reg == CNT_W'(DEPTH);
    assign empty    = fill_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/awsd_back.sv
module awsd_back #(
    parameter int ROW_W = 10
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             empty,
    output logic                             pop,
    input  awsd_pkg::item_t                  item_in,
    input  logic [ROW_W-1:0]                 row_in,
    input  logic [awsd_pkg::WEIGHT_BITS-1:0] near_weight,
    input  logic [awsd_pkg::WEIGHT_BITS-1:0] center_weight,
    input  logic [awsd_pkg::SELF_BITS-1:0]   self_weight,
    output logic                             out_valid,
    input  logic                             out_ready,
    output awsd_pkg::sample_t                out_data
);

    localparam int SB        = awsd_pkg::SAMPLE_BITS;
    localparam int SLOT_W    = awsd_pkg::SLOT_BITS;
    localparam int ADDR_W    = ROW_W + SLOT_W;
    localparam int MEM_DEPTH = 1 << ADDR_W;
    localparam int TAPS      = 8;
    localparam int TAP_W     = $bits(awsd_pkg::tap_t);
    localparam int CNT_W     = $clog2(TAPS + 1);
    localparam int SUM_W     = SB + 2;
    localparam int NEAR_W    = SUM_W + awsd_pkg::WEIGHT_BITS + 1;
    localparam int CEN_W     = SB + awsd_pkg::WEIGHT_BITS + 1;
    localparam int SELF_W    = SB + awsd_pkg::SELF_BITS + 1;
    localparam int LAP_W     = NEAR_W + 1;
    localparam int LO_W      = LAP_W / 2;
    localparam int HI_W      = LAP_W - LO_W;
    localparam int PLO_W     = awsd_pkg::VEL_BITS + LO_W;
    localparam int PHI_W     = awsd_pkg::VEL_BITS + 1 + HI_W;
    localparam int PROD_W    = LAP_W + awsd_pkg::VEL_BITS + 1;
    localparam int RND_W     = PROD_W - awsd_pkg::FRAC_BITS;
    localparam int RES_W     = RND_W + 2;

    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        PROD_W'(1) <<< (awsd_pkg::FRAC_BITS - 1);

    awsd_pkg::sample_t mem [MEM_DEPTH];

    awsd_pkg::back_state_t state_reg, state_next;
    logic [CNT_W-1:0]      rd_cnt_reg, rd_cnt_next;
    awsd_pkg::item_t       item_reg;
    logic [ROW_W-1:0]      row_reg;
    awsd_pkg::sample_t     rd_data_reg;
    awsd_pkg::sample_t     c_reg;
    logic signed [SUM_W-1:0]  s1_reg, s2_reg;
    logic signed [NEAR_W-1:0] near_p_reg;
    logic signed [CEN_W-1:0]  cen_p_reg;
    logic signed [SELF_W-1:0] self_p_reg;
    logic signed [LAP_W-1:0]  lap_reg;
    logic [PLO_W-1:0]         plo_reg;
    logic signed [PHI_W-1:0]  phi_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    awsd_pkg::sample_t        res_reg;
    logic                     out_valid_reg, out_valid_next;
    awsd_pkg::sample_t        out_data_reg;

    logic                  rd_en, wr_en, load_out;
    logic [ADDR_W-1:0]     rd_addr, wr_addr;
    awsd_pkg::tap_t        tap_issue, tap_back;
    logic [CNT_W-1:0]      rd_cnt_prev;
    logic [SLOT_W-1:0]     slot_center;
    logic signed [PROD_W-1:0] prod;
    logic signed [RES_W-1:0]  total;
    awsd_pkg::sample_t        sat;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        pop         = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        load_out    = 1'b0;
        unique case (state_reg)
            awsd_pkg::BK_IDLE:
            begin
                if (!empty)
                begin
                    pop         = 1'b1;
                    rd_cnt_next = '0;
                    state_next  = item_in.emit ? awsd_pkg::BK_READ : awsd_pkg::BK_DONE;
                end
            end
            awsd_pkg::BK_READ:
            begin
                rd_en       = rd_cnt_reg < CNT_W'(TAPS);
                rd_cnt_next = rd_cnt_reg + 1'b1;
                if (rd_cnt_reg == CNT_W'(TAPS))
                begin
                    state_next = awsd_pkg::BK_MUL;
                end
            end
            awsd_pkg::BK_MUL:   state_next = awsd_pkg::BK_LAP;
            awsd_pkg::BK_LAP:   state_next = awsd_pkg::BK_VEL;
            awsd_pkg::BK_VEL:   state_next = awsd_pkg::BK_ROUND;
            awsd_pkg::BK_ROUND: state_next = awsd_pkg::BK_SUM;
            awsd_pkg::BK_SUM:   state_next = awsd_pkg::BK_DONE;
            awsd_pkg::BK_DONE:
            begin
                // The sample is written only once its result has a place to go.
                if (!item_reg.emit || !out_valid_reg || out_ready)
                begin
                    wr_en      = 1'b1;
                    load_out   = item_reg.emit;
                    state_next = awsd_pkg::BK_IDLE;
                end
            end
        endcase
        out_valid_next = load_out || (out_valid_reg && !out_ready);
    end

    // Read addresses: slot + 2 holds the center column, slot + 1 and slot + 3
    // the columns one step away, slot itself the column two steps back.
    always_comb
    begin
        slot_center = item_reg.slot + SLOT_W'(2);
        tap_issue   = awsd_pkg::tap_t'(rd_cnt_reg[TAP_W-1:0]);
        rd_cnt_prev = rd_cnt_reg - 1'b1;
        tap_back    = awsd_pkg::tap_t'(rd_cnt_prev[TAP_W-1:0]);
        wr_addr     = {item_reg.slot, row_reg};
        unique case (tap_issue)
            awsd_pkg::TAP_CENTER: rd_addr = {slot_center, row_reg};
            awsd_pkg::TAP_ROW_M1: rd_addr = {slot_center, row_reg - ROW_W'(1)};
            awsd_pkg::TAP_ROW_P1: rd_addr = {slot_center, row_reg + ROW_W'(1)};
            awsd_pkg::TAP_LEFT1:  rd_addr = {item_reg.slot + SLOT_W'(1), row_reg};
            awsd_pkg::TAP_RIGHT1: rd_addr = {item_reg.slot + SLOT_W'(3), row_reg};
            awsd_pkg::TAP_ROW_M2: rd_addr = {slot_center, row_reg - ROW_W'(2)};
            awsd_pkg::TAP_ROW_P2: rd_addr = {slot_center, row_reg + ROW_W'(2)};
            awsd_pkg::TAP_LEFT2:  rd_addr = {item_reg.slot, row_reg};
        endcase
    end

    always_comb
    begin
        prod = (PROD_W'(phi_reg) <<< LO_W) + $signed(PROD_W'(plo_reg)) + ROUND_HALF;
        total = RES_W'(rnd_reg) + RES_W'(self_p_reg) - RES_W'(item_reg.prev);
        if (total > RES_W'(awsd_pkg::SAMPLE_MAX))
        begin
            sat = awsd_pkg::SAMPLE_MAX;
        end
        else if (total < RES_W'(awsd_pkg::SAMPLE_MIN))
        begin
            sat = awsd_pkg::SAMPLE_MIN;
        end
        else
        begin
            sat = SB'(total);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= item_reg.sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item_in;
            row_reg  <= row_in;
            s1_reg   <= '0;
            // The newest sample is the right-hand distance-two neighbor.
            s2_reg   <= SUM_W'(item_in.sample);
        end
        if (state_reg == awsd_pkg::BK_READ && rd_cnt_reg != '0)
        begin
            unique case (tap_back)
                awsd_pkg::TAP_CENTER: c_reg <= rd_data_reg;
                awsd_pkg::TAP_ROW_M1,
                awsd_pkg::TAP_ROW_P1,
                awsd_pkg::TAP_LEFT1,
                awsd_pkg::TAP_RIGHT1: s1_reg <= s1_reg + SUM_W'(rd_data_reg);
                awsd_pkg::TAP_ROW_M2,
                awsd_pkg::TAP_ROW_P2,
                awsd_pkg::TAP_LEFT2:  s2_reg <= s2_reg + SUM_W'(rd_data_reg);
            endcase
        end
        if (state_reg == awsd_pkg::BK_MUL)
        begin
            near_p_reg <= s1_reg * $signed({1'b0, near_weight});
            cen_p_reg  <= c_reg * $signed({1'b0, center_weight});
            self_p_reg <= c_reg * $signed({1'b0, self_weight});
        end
        if (state_reg == awsd_pkg::BK_LAP)
        begin
            lap_reg <= LAP_W'(near_p_reg) - LAP_W'(s2_reg) - LAP_W'(cen_p_reg);
        end
        if (state_reg == awsd_pkg::BK_VEL)
        begin
            // The velocity product is split into two partial products.
            plo_reg <= item_reg.vel * lap_reg[LO_W-1:0];
            phi_reg <= $signed({1'b0, item_reg.vel}) * $signed(lap_reg[LAP_W-1:LO_W]);
        end
        if (state_reg == awsd_pkg::BK_ROUND)
        begin
            rnd_reg <= RND_W'(prod >>> awsd_pkg::FRAC_BITS);
        end
        if (state_reg == awsd_pkg::BK_SUM)
        begin
            res_reg <= sat;
        end
        if (load_out)
        begin
            out_data_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awsd_pkg::BK_IDLE;
            rd_cnt_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_cnt_reg    <= rd_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: rtl/acoustic_wave_stencil_2d.sv
// Channel   Direction  Payload (lowest bits first)
// s_axis    in         tuser: frame_start; tdata: field_sample, center_vel, center_prev
// m_axis    out        tdata: new_pressure
// cfg       in         cfg_index selects the register, cfg_data carries its value
//
// A sample that completes an interior point is taken from the queue, then makes
// the eight reads on the single read port of the column store, passes through
// five arithmetic stages and is finally written and delivered.
// A sample that gives no result is taken from the queue and then written.
// Reset is asynchronous; the column store is not cleared and needs no sweep.
// A stalled result holds in the output register while the front end keeps
// taking transactions until its two-entry queue fills.
module acoustic_wave_stencil_2d #(
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // tdata: field_sample [31:0], center_vel [47:32], center_prev [79:48]
    input  logic [awsd_pkg::IN_DATA_BITS-1:0]       s_axis_tdata,
    // tuser: frame_start [0]
    input  logic                                    s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // tdata: new_pressure [31:0]
    output logic [awsd_pkg::SAMPLE_BITS-1:0]        m_axis_tdata,
    input  logic                                    cfg_we,
    input  logic [awsd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [awsd_pkg::HEIGHT_BITS-1:0]        cfg_data
);

    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int CMP_W = (H_W > awsd_pkg::HEIGHT_BITS) ? H_W : awsd_pkg::HEIGHT_BITS;
    localparam int SB    = awsd_pkg::SAMPLE_BITS;
    localparam int VB    = awsd_pkg::VEL_BITS;
    localparam int Q_W   = $bits(awsd_pkg::item_t) + ROW_W;

    // Configuration registers, taken straight from the write port.
    logic [awsd_pkg::HEIGHT_BITS-1:0] column_height_reg;
    logic [awsd_pkg::WEIGHT_BITS-1:0] near_weight_reg;
    logic [awsd_pkg::WEIGHT_BITS-1:0] center_weight_reg;
    logic [awsd_pkg::SELF_BITS-1:0]   self_weight_reg;

    logic [CMP_W-1:0]      height_ext;
    logic [CMP_W-1:0]      height_clamped;
    logic [H_W-1:0]        height;

    logic                  q_push, q_pop, q_full, q_empty;
    awsd_pkg::item_t       front_item, back_item;
    logic [ROW_W-1:0]      front_row, back_row;
    logic [Q_W-1:0]        q_pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_height_reg <= awsd_pkg::HEIGHT_RESET;
            near_weight_reg   <= awsd_pkg::NEAR_RESET;
            center_weight_reg <= awsd_pkg::CENTER_RESET;
            self_weight_reg   <= awsd_pkg::SELF_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                awsd_pkg::REG_HEIGHT: column_height_reg <= cfg_data;
                awsd_pkg::REG_NEAR:   near_weight_reg   <= cfg_data[awsd_pkg::WEIGHT_BITS-1:0];
                awsd_pkg::REG_CENTER: center_weight_reg <= cfg_data[awsd_pkg::WEIGHT_BITS-1:0];
                awsd_pkg::REG_SELF:   self_weight_reg   <= cfg_data[awsd_pkg::SELF_BITS-1:0];
            endcase
        end
    end

    // The programmed height is clamped to what the stencil and the column
    // store can hold, so any register value gives a usable geometry.
    always_comb
    begin
        height_ext = CMP_W'(column_height_reg);
        if (height_ext > CMP_W'(MAX_HEIGHT))
        begin
            height_clamped = CMP_W'(MAX_HEIGHT);
        end
        else if (height_ext < CMP_W'(awsd_pkg::MIN_HEIGHT))
        begin
            height_clamped = CMP_W'(awsd_pkg::MIN_HEIGHT);
        end
        else
        begin
            height_clamped = height_ext;
        end
        height = H_W'(height_clamped);
    end

    // Front end: tracks row, ring slot and column count and decides whether
    // each sample completes an interior point.
    awsd_front #(
        .ROW_W (ROW_W),
        .H_W   (H_W)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .frame_start  (s_axis_tuser),
        .field_sample (s_axis_tdata[SB-1:0]),
        .center_vel   (s_axis_tdata[SB+VB-1:SB]),
        .center_prev  (s_axis_tdata[2*SB+VB-1:SB+VB]),
        .height       (height),
        .full         (q_full),
        .push         (q_push),
        .item         (front_item),
        .row          (front_row)
    );

    // Short queue so that the front end keeps accepting while the back end
    // reads the column store or waits on the output.
    awsd_queue #(
        .WIDTH (Q_W),
        .DEPTH (awsd_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({front_row, front_item}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    assign back_item = q_pop_data[$bits(awsd_pkg::item_t)-1:0];
    assign back_row  = q_pop_data[Q_W-1:$bits(awsd_pkg::item_t)];

    // Back end: column store, stencil arithmetic and the output register.
    awsd_back #(
        .ROW_W (ROW_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .empty         (q_empty),
        .pop           (q_pop),
        .item_in       (back_item),
        .row_in        (back_row),
        .near_weight   (near_weight_reg),
        .center_weight (center_weight_reg),
        .self_weight   (self_weight_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata)
    );

endmodule

// File: rtl/awsd_check.sv
`include "acoustic_wave_stencil_2d_macros.svh"

module awsd_check (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [awsd_pkg::SAMPLE_BITS-1:0] m_axis_tdata
);

    // Four full columns of the shortest height plus the rows up to the
    // first interior point must pass before any result can exist.
    localparam int MIN_INPUTS = 4 * awsd_pkg::MIN_HEIGHT + awsd_pkg::HALO + 1;
    localparam int CNT_W      = $clog2(MIN_INPUTS + 1);

    logic [CNT_W-1:0] in_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg <= '0;
        end
        else if (s_axis_tvalid && s_axis_tready && in_cnt_reg != CNT_W'(MIN_INPUTS))
        begin
            in_cnt_reg <= in_cnt_reg + 1'b1;
        end
    end

    `AWSD_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed or dropped")
    `AWSD_ASSERT_IMP(a_out_warmup, m_axis_tvalid, in_cnt_reg == CNT_W'(MIN_INPUTS), "result before the stencil could be filled")
    `AWSD_ASSERT_IMP(a_ready_low, !s_axis_tready, in_cnt_reg >= CNT_W'(awsd_pkg::QUEUE_DEPTH), "input stalled with queue not yet filled")

endmodule

bind acoustic_wave_stencil_2d awsd_check u_check (.*);
